### design/lzsd_pkg.sv
// Shared constants and the command word passed from the parser to the copy engine.
`timescale 1ns / 1ps
`default_nettype none
package lzsd_pkg;

    localparam int HISTORY_BITS_DEF = 12;
    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 32;
    localparam int DIST_W           = 13;
    localparam int LEN_W            = 5;
    localparam int OFFSET_BITS      = 12;
    localparam int MIN_MATCH        = 3;
    localparam int CMD_FIFO_DEPTH   = 4;
    localparam int USER_W           = 3;

    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_BEFORE_START = 2'd1,
        ERR_CLIPPED      = 2'd2
    } err_code_t;

    typedef struct packed {
        logic               is_match;
        logic [BYTE_W-1:0]  lit;
        logic [DIST_W-1:0]  match_dist;
        logic [LEN_W-1:0]   cnt;
        logic               clipped;
        logic               ends_stream;
        logic               new_stream;
    } cmd_t;

endpackage
`default_nettype wire

### design/lzsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### design/lzsd_front.sv
// Front end: parses header, flag, literal and token bytes into copy commands.
`timescale 1ns / 1ps
`default_nettype none
module lzsd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lzsd_pkg::BYTE_W-1:0]   s_tdata,
    input  wire logic                          cmd_full,
    output logic                               cmd_push,
    output lzsd_pkg::cmd_t                     cmd_data
);
    import lzsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_HDR3  = 3'd3,
        PH_FLAG  = 3'd4,
        PH_ITEM  = 3'd5,
        PH_TOKLO = 3'd6
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  hdr_reg, hdr_next;
    logic [COUNT_W-1:0]  remaining_reg, remaining_next;
    logic [BYTE_W-1:0]   flag_bits_reg, flag_bits_next;
    logic [3:0]          flag_index_reg, flag_index_next;
    logic [BYTE_W-1:0]   token_high_reg, token_high_next;
    logic                new_stream_reg, new_stream_next;

    logic                accept;
    logic [15:0]         token;
    logic [LEN_W-1:0]    len;
    logic [DIST_W-1:0]   match_dist;
    logic                len_ge;
    logic                clipped;
    logic [LEN_W-1:0]    cnt;
    logic [3:0]          idx_inc;
    logic [COUNT_W-1:0]  hdr_shift;

    assign s_tready   = !cmd_full;
    assign accept     = s_tvalid && !cmd_full;
    assign token      = {token_high_reg, s_tdata};
    assign len        = LEN_W'(token[15:OFFSET_BITS]) + LEN_W'(MIN_MATCH);
    assign match_dist = DIST_W'(token[OFFSET_BITS-1:0]) + DIST_W'(1);
    assign len_ge     = COUNT_W'(len) >= remaining_reg;
    assign clipped    = COUNT_W'(len) > remaining_reg;
    assign cnt        = len_ge ? remaining_reg[LEN_W-1:0] : len;
    assign idx_inc    = flag_index_reg + 4'd1;
    assign hdr_shift  = {hdr_reg[COUNT_W-BYTE_W-1:0], s_tdata};

    always_comb begin
        phase_next      = phase_reg;
        hdr_next        = hdr_reg;
        remaining_next  = remaining_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        token_high_next = token_high_reg;
        new_stream_next = new_stream_reg;
        cmd_push        = 1'b0;
        cmd_data.is_match    = 1'b0;
        cmd_data.lit         = s_tdata;
        cmd_data.match_dist  = match_dist;
        cmd_data.cnt         = LEN_W'(1);
        cmd_data.clipped     = 1'b0;
        cmd_data.ends_stream = 1'b0;
        cmd_data.new_stream  = new_stream_reg;
        if (accept) begin
            unique case (phase_reg) inside
                PH_HDR0, PH_HDR1, PH_HDR2: begin
                    hdr_next   = hdr_shift;
                    phase_next = (phase_reg == PH_HDR0) ? PH_HDR1 :
                                 (phase_reg == PH_HDR1) ? PH_HDR2 : PH_HDR3;
                end
                PH_HDR3: begin
                    hdr_next        = hdr_shift;
                    remaining_next  = hdr_shift;
                    flag_index_next = 4'd0;
                    new_stream_next = 1'b1;
                    phase_next      = (hdr_shift == '0) ? PH_HDR0 : PH_FLAG;
                end
                PH_FLAG: begin
                    flag_bits_next  = s_tdata;
                    flag_index_next = 4'd0;
                    phase_next      = PH_ITEM;
                end
                PH_ITEM: begin
                    if (!flag_bits_reg[flag_index_reg[2:0]]) begin
                        cmd_push             = 1'b1;
                        cmd_data.ends_stream = (remaining_reg == COUNT_W'(1));
                        remaining_next       = remaining_reg - COUNT_W'(1);
                        new_stream_next      = 1'b0;
                        flag_index_next      = idx_inc;
                        phase_next = (remaining_reg == COUNT_W'(1)) ? PH_HDR0 :
                                     idx_inc[3] ? PH_FLAG : PH_ITEM;
                    end else begin
                        token_high_next = s_tdata;
                        phase_next      = PH_TOKLO;
                    end
                end
                PH_TOKLO: begin
                    cmd_push             = 1'b1;
                    cmd_data.is_match    = 1'b1;
                    cmd_data.cnt         = cnt;
                    cmd_data.clipped     = clipped;
                    cmd_data.ends_stream = len_ge;
                    remaining_next       = remaining_reg - COUNT_W'(cnt);
                    new_stream_next      = 1'b0;
                    flag_index_next      = idx_inc;
                    phase_next = len_ge ? PH_HDR0 : idx_inc[3] ? PH_FLAG : PH_ITEM;
                end
                default: begin
                    // unused code: acts as first header byte
                    hdr_next   = COUNT_W'(s_tdata);
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR0;
            hdr_reg        <= '0;
            remaining_reg  <= '0;
            flag_bits_reg  <= '0;
            flag_index_reg <= '0;
            token_high_reg <= '0;
            new_stream_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_reg        <= hdr_next;
            remaining_reg  <= remaining_next;
            flag_bits_reg  <= flag_bits_next;
            flag_index_reg <= flag_index_next;
            token_high_reg <= token_high_next;
            new_stream_reg <= new_stream_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ITEM || phase_reg == PH_TOKLO) |-> remaining_reg != '0)
        else $error("item phase with nothing left to decode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push && cmd_data.ends_stream |=> phase_reg == PH_HDR0)
        else $error("stream end did not re-arm header parsing");

endmodule
`default_nettype wire

### design/lzsd_cmd_fifo.sv
// Short command queue between the parser and the copy engine.
`timescale 1ns / 1ps
`default_nettype none
module lzsd_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  lzsd_pkg::cmd_t      push_data,
    output logic                full,
    input  wire logic           pop,
    output lzsd_pkg::cmd_t      pop_data,
    output logic                not_empty
);
    import lzsd_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             mem_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) full |-> !push)
        else $error("command queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn) !not_empty |-> !pop)
        else $error("command queue underflow");

endmodule
`default_nettype wire

### design/lzsd_back.sv
// Back end: expands commands into bytes, keeps the history RAM, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module lzsd_back #(
    parameter int HISTORY_BITS = lzsd_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    input  lzsd_pkg::cmd_t                     cmd_data,
    output logic                               cmd_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lzsd_pkg::BYTE_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic      [lzsd_pkg::USER_W-1:0]   m_tuser
);
    import lzsd_pkg::*;

    localparam int HIST_DEPTH = 1 << HISTORY_BITS;

    // issue stage
    logic                    act_valid_reg;
    cmd_t                    act_reg;
    logic [LEN_W-1:0]        j_reg;
    logic [HISTORY_BITS-1:0] wp_reg;
    logic [DIST_W-1:0]       p_reg;

    // data stage
    logic                    b_valid_reg;
    logic                    b_from_ram_reg;
    logic [BYTE_W-1:0]       b_val_reg;
    logic [HISTORY_BITS-1:0] b_addr_reg;
    logic                    b_last_reg;
    logic                    b_end_reg;
    err_code_t               b_err_reg;
    logic                    byp_reg;
    logic [BYTE_W-1:0]       byp_data_reg;

    // output register
    logic                    m_valid_reg;
    logic [BYTE_W-1:0]       m_data_reg;
    logic                    m_last_reg;
    logic [USER_W-1:0]       m_user_reg;

    logic                    b_adv;
    logic                    issue;
    logic                    a_last;
    logic                    a_err1;
    logic                    a_from_ram;
    err_code_t               a_err;
    logic [HISTORY_BITS-1:0] rd_addr;
    logic [BYTE_W-1:0]       ram_q;
    logic [BYTE_W-1:0]       b_value;

    assign b_adv      = b_valid_reg && (!m_valid_reg || m_tready);
    assign issue      = act_valid_reg && (!b_valid_reg || b_adv);
    assign a_last     = (j_reg == LEN_W'(act_reg.cnt - LEN_W'(1)));
    assign cmd_pop    = cmd_valid && (!act_valid_reg || (issue && a_last));
    assign a_err1     = act_reg.is_match && (act_reg.match_dist > p_reg);
    assign a_from_ram = act_reg.is_match && !a_err1;
    assign rd_addr    = wp_reg - HISTORY_BITS'(act_reg.match_dist);
    assign b_value    = b_from_ram_reg ? (byp_reg ? byp_data_reg : ram_q) : b_val_reg;

    always_comb begin
        if (!act_reg.is_match) begin
            a_err = ERR_OK;
        end else if (a_err1) begin
            a_err = ERR_BEFORE_START;
        end else if (act_reg.clipped) begin
            a_err = ERR_CLIPPED;
        end else begin
            a_err = ERR_OK;
        end
    end

    lzsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (b_adv),
        .waddr (b_addr_reg),
        .wdata (b_value),
        .re    (issue && a_from_ram),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
            j_reg         <= '0;
            wp_reg        <= '0;
            p_reg         <= '0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (issue) begin
                j_reg  <= j_reg + LEN_W'(1);
                wp_reg <= wp_reg + HISTORY_BITS'(1);
                if (!p_reg[DIST_W-1]) begin
                    p_reg <= p_reg + DIST_W'(1);
                end
                if (a_last) begin
                    act_valid_reg <= 1'b0;
                end
            end
            if (cmd_pop) begin
                act_valid_reg <= 1'b1;
                j_reg         <= '0;
                if (cmd_data.new_stream) begin
                    wp_reg <= '0;
                    p_reg  <= '0;
                end
            end
            if (issue) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            act_reg <= cmd_data;
        end
        if (issue) begin
            b_from_ram_reg <= a_from_ram;
            b_val_reg      <= act_reg.is_match ? '0 : act_reg.lit;
            b_addr_reg     <= wp_reg;
            b_last_reg     <= a_last;
            b_end_reg      <= a_last && act_reg.ends_stream;
            b_err_reg      <= a_err;
            // read collides with the write of the byte just ahead
            byp_reg        <= b_adv && (rd_addr == b_addr_reg);
            byp_data_reg   <= b_value;
        end
        if (b_adv) begin
            m_data_reg <= b_value;
            m_last_reg <= b_last_reg;
            m_user_reg <= {b_err_reg, b_end_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        act_valid_reg |-> j_reg < act_reg.cnt)
        else $error("byte index ran past command length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[0] |-> m_last_reg)
        else $error("stream end on a byte that is not last of its run");

endmodule
`default_nettype wire

### design/lzss_stream_decoder_core.sv
// Top level of the LZSS stream decoder.
`timescale 1ns / 1ps
`default_nettype none
// Decodes an LZSS byte stream (4-byte big-endian length header, LSB-first
// flag bytes, literals and 16-bit tokens with 4-bit length and 12-bit
// distance). The parser takes one compressed byte per cycle while its
// 4-entry command queue has room; header, flag and first token bytes give
// no output. The copy engine emits one decoded byte per cycle while commands
// are queued and the receiver is ready; a literal gives one byte and a match
// 3 to 18 bytes, fewer when clipped at the stream end. An accepted byte
// passes the command queue, the issue stage, the data stage and the output
// register. History lives in one 2**HISTORY_BITS-byte RAM; reads that hit
// the byte written in the same cycle are forwarded. No clearing pass after reset.
module lzss_stream_decoder_core #(
    parameter int HISTORY_BITS = lzsd_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lzsd_pkg::BYTE_W-1:0]   s_tdata,   // in_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lzsd_pkg::BYTE_W-1:0]   m_tdata,   // out_byte
    output logic                               m_tlast,   // run_last
    output logic      [lzsd_pkg::USER_W-1:0]   m_tuser    // stream_end, error_code[1:0]
);
    import lzsd_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_avail;

    lzsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (push_cmd)
    );

    lzsd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (head_cmd),
        .not_empty (cmd_avail)
    );

    lzsd_back #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_avail),
        .cmd_data  (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

### bench/lzss_stream_decoder_core_tb.sv
// Self-checking bench for the LZSS stream decoder core, predicting each decoded word.
`timescale 1ns / 1ps
module lzss_stream_decoder_core_tb;
    import lzsd_pkg::*;

    localparam int HIST_DEPTH   = 1 << HISTORY_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 130;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_FLAG,
        ST_ITEM,
        ST_TOKEN_LO
    } parse_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              done;
        err_code_t         err;
    } out_word_t;

    typedef logic [BYTE_W-1:0] byte_seq_t[$];

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [USER_W-1:0]   m_tuser;

    // decoder state mirrored by the bench
    parse_state_t        st        = ST_HEADER;
    int unsigned         hdr_idx   = 0;
    logic [31:0]         dec_total = '0;
    int unsigned         dec_count = 0;
    logic [7:0]          flags     = '0;
    logic [3:0]          flag_idx  = '0;
    logic [7:0]          tok_hi    = '0;
    logic [7:0]          hist [HIST_DEPTH];
    out_word_t           out_q[$];

    int mismatches        = 0;
    int words_sent        = 0;
    int bytes_checked     = 0;
    int streams_done      = 0;
    int before_start_seen = 0;
    int clipped_seen      = 0;
    int cycle_count       = 0;
    int src_gap_max       = 19;
    int sink_gap_max      = 19;
    int sink_hold         = 0;

    lzss_stream_decoder_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     out_q.size());
            $display("lzss_stream_decoder_core_tb NOT OK");
            $finish;
        end
    end

    function automatic void put_byte(input logic [7:0] v, input err_code_t e);
        out_word_t w;
        hist[HISTORY_BITS_DEF'(dec_count)] = v;
        dec_count++;
        w.data = v;
        w.last = 1'b0;
        w.done = (dec_count == dec_total);
        w.err  = e;
        out_q.push_back(w);
    endfunction

    function automatic void next_item();
        flag_idx = flag_idx + 4'd1;
        if (dec_count == dec_total) begin
            st = ST_HEADER;
            streams_done++;
        end else if (flag_idx >= 4'd8) begin
            st = ST_FLAG;
        end else begin
            st = ST_ITEM;
        end
    endfunction

    // expected decoded words for one accepted compressed word
    function automatic void decode_word(input logic [7:0] b);
        int          n;
        logic [15:0] tok;
        int unsigned run, match_dist, left, cnt;
        bit          clip;
        logic [7:0]  v;
        err_code_t   e;
        out_word_t   w;
        n = 0;
        case (st)
            ST_HEADER: begin
                dec_total = {dec_total[23:0], b};
                if (hdr_idx == 3) begin
                    hdr_idx   = 0;
                    dec_count = 0;
                    flag_idx  = '0;
                    if (dec_total == 0) begin
                        st = ST_HEADER;
                        streams_done++;
                    end else begin
                        st = ST_FLAG;
                    end
                end else begin
                    hdr_idx++;
                end
            end
            ST_FLAG: begin
                flags    = b;
                flag_idx = '0;
                st       = ST_ITEM;
            end
            ST_ITEM: begin
                if (!flags[flag_idx[2:0]]) begin
                    put_byte(b, ERR_OK);
                    n = 1;
                    next_item();
                end else begin
                    tok_hi = b;
                    st     = ST_TOKEN_LO;
                end
            end
            default: begin
                tok        = {tok_hi, b};
                run        = tok[15:12] + 3;
                match_dist = tok[11:0] + 1;
                left       = dec_total - dec_count;
                clip       = run > left;
                cnt        = clip ? left : run;
                for (int j = 0; j < cnt; j++) begin
                    e = clip ? ERR_CLIPPED : ERR_OK;
                    v = '0;
                    if (match_dist > dec_count)
                        e = ERR_BEFORE_START;
                    else
                        v = hist[HISTORY_BITS_DEF'(dec_count - match_dist)];
                    put_byte(v, e);
                    n++;
                end
                next_item();
            end
        endcase
        if (n > 0) begin
            w = out_q[out_q.size() - 1];
            w.last = 1'b1;
            out_q[out_q.size() - 1] = w;
        end
    endfunction

    function automatic logic [15:0] pick_token(input bit max_run);
        int unsigned run, match_dist, reach, r;
        run   = max_run ? 18 : $urandom_range(3, 18);
        reach = (dec_count < HIST_DEPTH) ? dec_count : HIST_DEPTH;
        if (reach == 0)
            reach = 1;
        r = $urandom_range(0, 99);
        if (r < 12)
            match_dist = $urandom_range(1, HIST_DEPTH);
        else if (r < 20)
            match_dist = reach;
        else if (r < 60)
            match_dist = $urandom_range(1, reach);
        else
            match_dist = $urandom_range(1, (reach < 20) ? reach : 20);
        return {4'(run - 3), 12'(match_dist - 1)};
    endfunction

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_word(b);
        words_sent++;
    endtask

    task automatic send_bytes(input byte_seq_t seq);
        foreach (seq[i]) send_word(seq[i]);
    endtask

    task automatic wait_drained();
        if (out_q.size() != 0) begin
            s_tvalid <= 1'b0;
            while (out_q.size() != 0) @(posedge aclk);
        end
    endtask

    // one complete stream: header, then flags and items until the length is reached
    task automatic send_stream(input logic [31:0] len, input int tok_pct, input bit max_run);
        logic [7:0]  fl;
        logic [15:0] tok;
        for (int i = 3; i >= 0; i--)
            send_word(len[i*8 +: 8]);
        while (st != ST_HEADER) begin
            case (st)
                ST_FLAG: begin
                    for (int k = 0; k < 8; k++)
                        fl[k] = ($urandom_range(0, 99) < tok_pct);
                    send_word(fl);
                end
                ST_ITEM: begin
                    if (flags[flag_idx[2:0]]) begin
                        tok = pick_token(max_run);
                        send_word(tok[15:8]);
                        send_word(tok[7:0]);
                    end else begin
                        send_word(8'($urandom_range(0, 255)));
                    end
                end
                default: send_word(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_zero_length();
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    // literal, then a length-18 distance-1 match clipped at the end; leftover flags dropped
    task automatic test_overlap_clip();
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h0A, 8'h0A, 8'h5A, 8'hF0, 8'h00});
    endtask

    // repeat of a literal, then a match starting before the stream start
    task automatic test_before_start();
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h07, 8'h06, 8'hFF, 8'h00, 8'h00,
                     8'h00, 8'h05});
    endtask

    task automatic test_random_streams();
        int unsigned first, len;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            if ($urandom_range(0, 3) == 0) begin
                src_gap_max  = 0;
                sink_gap_max = 0;
            end else begin
                src_gap_max  = 19;
                sink_gap_max = 19;
            end
            case ($urandom_range(0, 19)) inside
                0:       len = 0;
                [1:3]:   len = $urandom_range(49, 400);
                default: len = $urandom_range(1, 48);
            endcase
            send_stream(len, $urandom_range(10, 70), 1'b0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        src_gap_max  = 19;
        sink_gap_max = 19;
    endtask

    // long receiver stall while input keeps coming, then a full drain
    task automatic test_backpressure();
        src_gap_max = 0;
        sink_hold   = 400;
        send_stream(200, 40, 1'b0);
        wait_drained();
        src_gap_max = 19;
    endtask

    // back-to-back maximum-length matches, distances up to the full history depth
    task automatic test_max_matches();
        src_gap_max  = 0;
        sink_gap_max = 0;
        send_stream(32'd600, 95, 1'b1);
        wait_drained();
        src_gap_max  = 19;
        sink_gap_max = 19;
    endtask

    // huge length that never completes
    task automatic test_open_stream();
        send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'h80});
    endtask

    initial begin : sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end else begin
                gap = $urandom_range(0, sink_gap_max);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_results
        out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %02h last %0d user %03b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = out_q.pop_front();
                if (want.err == ERR_BEFORE_START)
                    before_start_seen++;
                if (want.err == ERR_CLIPPED)
                    clipped_seen++;
                if (m_tdata !== want.data || m_tlast !== want.last ||
                    m_tuser[0] !== want.done || m_tuser[2:1] !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d: expected data %02h last %0d end %0d err %0d, ",
                                  "got %02h %0d %0d %0d"},
                                 bytes_checked, want.data, want.last, want.done, want.err,
                                 m_tdata, m_tlast, m_tuser[0], m_tuser[2:1]);
                end
            end
            bytes_checked++;
        end
    end

    initial begin : run_tests
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_zero_length();
        test_overlap_clip();
        test_before_start();
        test_random_streams();
        test_backpressure();
        test_max_matches();
        test_open_stream();
        s_tvalid <= 1'b0;
        while (out_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("%0d compressed words, %0d finished streams, %0d decoded words checked",
                 words_sent, streams_done, bytes_checked);
        $display("%0d before-start references, %0d clipped match words, %0d mismatches",
                 before_start_seen, clipped_seen, mismatches);
        if (mismatches == 0)
            $display("lzss_stream_decoder_core_tb OK");
        else
            $display("lzss_stream_decoder_core_tb NOT OK");
        $finish;
    end

endmodule
